// ===== src/snwm_pkg.sv =====
// Package for the serial needle wait matcher: widths, register indexes and shared types.
`default_nettype none
package snwm_pkg;

    // Needle geometry
    localparam int unsigned NEEDLE_MAX = 8;
    localparam int unsigned POS_W      = 3;
    localparam int unsigned LEN_W      = 4;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned NEEDLE_W   = NEEDLE_MAX * BYTE_W;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned CFG_W      = 64;
    localparam int unsigned IDX_W      = 2;

    // Register indexes on the write port
    localparam logic [IDX_W-1:0] REG_NEEDLE_BYTES  = 2'd0;
    localparam logic [IDX_W-1:0] REG_NEEDLE_LENGTH = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX_COUNT     = 2'd2;
    localparam logic [IDX_W-1:0] REG_STORE_MODE    = 2'd3;

    // Reset values of the registers
    localparam logic [NEEDLE_W-1:0] RST_NEEDLE_BYTES  = '0;
    localparam logic [LEN_W-1:0]    RST_NEEDLE_LENGTH = 4'd1;
    localparam logic [CNT_W-1:0]    RST_MAX_COUNT     = 16'hFFFF;
    localparam logic                RST_STORE_MODE    = 1'b1;

    localparam logic [CNT_W-1:0] CNT_SAT = 16'hFFFF;

    // Effective configuration, already saturated
    typedef struct packed {
        logic [NEEDLE_W-1:0] needle;
        logic [LEN_W-1:0]    length;  // 1..NEEDLE_MAX
        logic [CNT_W-1:0]    limit;   // 1..65535
        logic                store;
    } cfg_t;

    // One result transaction
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              keep_byte;
        logic [CNT_W-1:0]  stored_total;
        logic              needle_found;
        logic              search_done;
    } res_t;

endpackage
`default_nettype wire

// ===== src/serial_needle_wait_matcher_top.sv =====
// Top level of the serial needle wait matcher.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | s_tdata: rx_byte
//  m_*     | out       | m_tvalid/m_tready  | m_tdata, m_tuser, m_tlast (search_done)
//  cfg_*   | in        | cfg_we             | cfg_index, cfg_data
//
// One byte per cycle sustained while m_tready stays high. A byte goes from s_
// to m_ through the input register, then the result register. Match position
// and stored count update as a byte moves into the result register. A stalled
// m_ side holds one result and one waiting byte; then s_tready drops. Reset
// clears valid flags, search state and registers to their defaults.
`default_nettype none
module serial_needle_wait_matcher_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] rx_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [23:0]                        m_tdata,   // [7:0] data_byte, [23:8] stored_total
    output logic [1:0]                         m_tuser,   // [0] keep_byte, [1] needle_found
    output logic                               m_tlast,   // search_done
    input  wire logic                          cfg_we,
    input  wire logic [snwm_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [snwm_pkg::CFG_W-1:0]    cfg_data
);

    snwm_pkg::cfg_t cfg;
    snwm_pkg::res_t res;

    snwm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    snwm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Output packing
    assign m_tdata = {res.stored_total, res.data_byte};
    assign m_tuser = {res.needle_found, res.keep_byte};
    assign m_tlast = res.search_done;

endmodule
`default_nettype wire

// ===== src/snwm_cfg.sv =====
// Configuration registers of the matcher with saturation of length and limit.
`default_nettype none
module snwm_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [snwm_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [snwm_pkg::CFG_W-1:0]    cfg_data,
    output snwm_pkg::cfg_t                     cfg
);

    logic [snwm_pkg::NEEDLE_W-1:0] needle_reg;
    logic [snwm_pkg::LEN_W-1:0]    length_reg;
    logic [snwm_pkg::CNT_W-1:0]    max_count_reg;
    logic                          store_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_reg    <= snwm_pkg::RST_NEEDLE_BYTES;
            length_reg    <= snwm_pkg::RST_NEEDLE_LENGTH;
            max_count_reg <= snwm_pkg::RST_MAX_COUNT;
            store_reg     <= snwm_pkg::RST_STORE_MODE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                snwm_pkg::REG_NEEDLE_BYTES:
                    needle_reg <= cfg_data[snwm_pkg::NEEDLE_W-1:0];
                snwm_pkg::REG_NEEDLE_LENGTH:
                    length_reg <= cfg_data[snwm_pkg::LEN_W-1:0];
                snwm_pkg::REG_MAX_COUNT:
                    max_count_reg <= cfg_data[snwm_pkg::CNT_W-1:0];
                snwm_pkg::REG_STORE_MODE:
                    store_reg <= cfg_data[0];
                default:
                    store_reg <= store_reg;
            endcase
        end
    end

    // Zero length counts as one, long length clamps to the needle size, zero limit counts as one
    always_comb
    begin
        cfg.needle = needle_reg;
        cfg.store  = store_reg;
        if (length_reg == '0)
            cfg.length = snwm_pkg::LEN_W'(1);
        else if (length_reg > snwm_pkg::LEN_W'(snwm_pkg::NEEDLE_MAX))
            cfg.length = snwm_pkg::LEN_W'(snwm_pkg::NEEDLE_MAX);
        else
            cfg.length = length_reg;
        cfg.limit = (max_count_reg == '0) ? snwm_pkg::CNT_W'(1) : max_count_reg;
    end

endmodule
`default_nettype wire

// ===== src/snwm_core.sv =====
// Matcher datapath: input register, compare and count, result register.
`default_nettype none
module snwm_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire snwm_pkg::cfg_t                cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [snwm_pkg::BYTE_W-1:0]   in_byte,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output snwm_pkg::res_t                     out_res
);

    logic                          hold_valid_reg;
    logic [snwm_pkg::BYTE_W-1:0]   hold_byte_reg;
    logic                          res_valid_reg;
    snwm_pkg::res_t                res_reg;
    logic [snwm_pkg::POS_W-1:0]    pos_reg;
    logic [snwm_pkg::POS_W-1:0]    pos_next;
    logic [snwm_pkg::CNT_W-1:0]    cnt_reg;
    logic [snwm_pkg::CNT_W-1:0]    cnt_next;
    snwm_pkg::res_t                res_next;

    logic                          advance;
    logic [snwm_pkg::POS_W-1:0]    pos_cur;
    logic [snwm_pkg::LEN_W-1:0]    pos_inc;
    logic [snwm_pkg::BYTE_W-1:0]   want;
    logic [snwm_pkg::CNT_W-1:0]    cnt_inc;
    logic                          hit;
    logic                          found;
    logic                          done;

    // Pipeline moves when the result slot is free or being drained
    assign advance   = !res_valid_reg || out_ready;
    assign in_ready  = !hold_valid_reg || advance;
    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;

    // Compare against the needle byte at the current position
    always_comb
    begin
        pos_cur = (snwm_pkg::LEN_W'(pos_reg) >= cfg.length) ? '0 : pos_reg;
        want    = cfg.needle[pos_cur * snwm_pkg::BYTE_W +: snwm_pkg::BYTE_W];
        hit     = (hold_byte_reg == want);
        pos_inc = snwm_pkg::LEN_W'(pos_cur) + snwm_pkg::LEN_W'(1);
        found   = hit && (pos_inc >= cfg.length);

        cnt_inc = (cnt_reg < snwm_pkg::CNT_SAT) ? cnt_reg + snwm_pkg::CNT_W'(1) : cnt_reg;
        done    = found || (cfg.store && (cnt_inc >= cfg.limit));

        if (done)
        begin
            pos_next = '0;
            cnt_next = '0;
        end
        else
        begin
            pos_next = hit ? pos_inc[snwm_pkg::POS_W-1:0] : '0;
            cnt_next = cfg.store ? cnt_inc : cnt_reg;
        end

        res_next.data_byte    = hold_byte_reg;
        res_next.keep_byte    = cfg.store;
        res_next.stored_total = cfg.store ? cnt_inc : '0;
        res_next.needle_found = found;
        res_next.search_done  = done;
    end

    // Control registers and search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (in_ready)
                hold_valid_reg <= in_valid;
            if (advance)
                res_valid_reg <= hold_valid_reg;
            if (advance && hold_valid_reg)
            begin
                pos_reg <= pos_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            hold_byte_reg <= in_byte;
        if (advance && hold_valid_reg)
            res_reg <= res_next;
    end

endmodule
`default_nettype wire

// ===== tb/serial_needle_wait_matcher_checker.sv =====
// Result checker for the serial needle wait matcher: tracks config, predicts and compares.
module serial_needle_wait_matcher_checker
    import snwm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] rx_byte
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [23:0]         m_tdata,    // [7:0] data_byte, [23:8] stored_total
    input  logic [1:0]          m_tuser,    // [0] keep_byte, [1] needle_found
    input  logic                m_tlast,    // search_done
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    output int unsigned         mismatch_count,
    output int unsigned         results_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Register copies as written, before saturation
    logic [NEEDLE_W-1:0] needle;
    logic [LEN_W-1:0]    needle_len;
    logic [CNT_W-1:0]    max_count;
    logic                store_mode;

    // Search state
    logic [POS_W-1:0]    match_pos;
    logic [CNT_W-1:0]    stored_cnt;

    // Predicted results, oldest first
    res_t                scan_results_q[$];

    // Advance the search by one byte and return what the block should emit
    function automatic res_t scan_byte(input logic [7:0] rx);
        res_t        r;
        int unsigned span;
        int unsigned limit;
        int unsigned at;
        logic [7:0]  want;
        span = (needle_len == 0) ? 1 : int'(needle_len);
        if (span > NEEDLE_MAX)
            span = NEEDLE_MAX;
        limit = (max_count == 0) ? 1 : int'(max_count);
        at = int'(match_pos);
        // position left over from a longer needle starts over
        if (at >= span)
            at = 0;
        want = needle[8*at +: 8];
        r = '0;
        r.data_byte = rx;
        r.keep_byte = store_mode;
        // a miss drops back to zero without retrying the first needle byte
        if (rx == want)
        begin
            at++;
            if (at >= span)
            begin
                r.needle_found = 1'b1;
                r.search_done  = 1'b1;
                at = 0;
            end
        end
        else
        begin
            at = 0;
        end
        if (store_mode)
        begin
            if (stored_cnt != CNT_SAT)
                stored_cnt++;
            r.stored_total = stored_cnt;
            if (int'(stored_cnt) >= limit)
                r.search_done = 1'b1;
        end
        if (r.search_done)
        begin
            match_pos  = '0;
            stored_cnt = '0;
        end
        else
        begin
            match_pos = POS_W'(at);
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    // Config writes, input transactions and result transactions, all at the edge
    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_r;
        if (!rst_n)
        begin
            needle              = RST_NEEDLE_BYTES;
            needle_len          = RST_NEEDLE_LENGTH;
            max_count           = RST_MAX_COUNT;
            store_mode          = RST_STORE_MODE;
            match_pos           = '0;
            stored_cnt          = '0;
            mismatch_count      = 0;
            results_outstanding = 0;
            scan_results_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NEEDLE_BYTES:  needle     = cfg_data[NEEDLE_W-1:0];
                    REG_NEEDLE_LENGTH: needle_len = cfg_data[LEN_W-1:0];
                    REG_MAX_COUNT:     max_count  = cfg_data[CNT_W-1:0];
                    REG_STORE_MODE:    store_mode = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                scan_results_q.push_back(scan_byte(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (scan_results_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t ns: unexpected result, expected none, actual data 0x%0h",
                             $time, m_tdata);
                end
                else
                begin
                    exp_r = scan_results_q.pop_front();
                    compare_field("data_byte", exp_r.data_byte, m_tdata[7:0]);
                    compare_field("stored_total", exp_r.stored_total, m_tdata[23:8]);
                    compare_field("keep_byte", exp_r.keep_byte, m_tuser[0]);
                    compare_field("needle_found", exp_r.needle_found, m_tuser[1]);
                    compare_field("search_done", exp_r.search_done, m_tlast);
                end
            end
            results_outstanding = scan_results_q.size();
        end
    end

endmodule

// ===== tb/serial_needle_wait_matcher_top_tb.sv =====
// Testbench top for the serial needle wait matcher: clock, reset, stimulus and verdict.
module serial_needle_wait_matcher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import snwm_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = '0;     // [7:0] rx_byte
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [23:0]         m_tdata;          // [7:0] data_byte, [23:8] stored_total
    logic [1:0]          m_tuser;          // [0] keep_byte, [1] needle_found
    logic                m_tlast;          // search_done
    logic                cfg_we = 1'b0;
    logic [IDX_W-1:0]    cfg_index = REG_NEEDLE_BYTES;
    logic [CFG_W-1:0]    cfg_data = '0;

    int unsigned         mismatch_count;
    int unsigned         results_outstanding;

    // What was last written, for building needle traffic
    logic [NEEDLE_W-1:0] shadow_needle = RST_NEEDLE_BYTES;
    logic [LEN_W-1:0]    shadow_len = RST_NEEDLE_LENGTH;

    // Pacing controls
    bit                  src_fast;
    bit                  src_burst;
    bit                  sink_fast;
    bit                  hold_req;
    bit                  hold_served;

    serial_needle_wait_matcher_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    serial_needle_wait_matcher_checker match_check (
        .clk                 (clk),
        .rst_n               (rst_n),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .m_tuser             (m_tuser),
        .m_tlast             (m_tlast),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop
    initial
    begin
        #2_000_000;
        $display("serial_needle_wait_matcher_top_tb: errors");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transaction
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 15) == 0)
            src_fast = !src_fast;
        gap = (src_fast || src_burst) ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sender goes quiet until every predicted result is out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (results_outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_NEEDLE_BYTES)
            shadow_needle = value;
        else if (idx == REG_NEEDLE_LENGTH)
            shadow_len = value[LEN_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic int needle_span();
        if (shadow_len == 0)
            return 1;
        if (shadow_len > NEEDLE_MAX)
            return NEEDLE_MAX;
        return int'(shadow_len);
    endfunction

    // New settings for a phase; junk above the register width is deliberate
    task automatic random_setup(input bit all_regs);
        logic [CFG_W-1:0] v;
        logic [7:0]       base;
        int               k;
        if (all_regs || $urandom_range(0, 3) != 0)
        begin
            v = {$urandom, $urandom};
            // narrow alphabet so partial matches and restarts happen often
            if ($urandom_range(0, 2) != 0)
            begin
                base = 8'($urandom);
                for (k = 0; k < NEEDLE_MAX; k++)
                    v[8*k +: 8] = base + 8'($urandom_range(0, 2));
            end
            write_reg(REG_NEEDLE_BYTES, v);
        end
        if (all_regs || $urandom_range(0, 3) != 0)
        begin
            v = {$urandom, $urandom};
            case ($urandom_range(0, 7))
                0:       v[3:0] = 4'd0;
                1:       v[3:0] = 4'($urandom_range(9, 15));
                default: v[3:0] = 4'($urandom_range(1, 8));
            endcase
            write_reg(REG_NEEDLE_LENGTH, v);
        end
        if (all_regs || $urandom_range(0, 3) != 0)
        begin
            v = {$urandom, $urandom};
            case ($urandom_range(0, 7))
                0:       v[15:0] = 16'd0;
                1:       v[15:0] = 16'hFFFF;
                2:       v[15:0] = 16'($urandom);
                default: v[15:0] = 16'($urandom_range(1, 24));
            endcase
            write_reg(REG_MAX_COUNT, v);
        end
        if (all_regs || $urandom_range(0, 3) != 0)
            write_reg(REG_STORE_MODE, {$urandom, $urandom});
    endtask

    // Mostly needle runs, some cut short, plus needle-alphabet and plain noise
    task automatic random_traffic(input int count);
        int sent;
        int k;
        int run;
        int span;
        sent = 0;
        while (sent < count)
        begin
            span = needle_span();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span) : span;
                    for (k = 0; k < run; k++)
                        push_byte(shadow_needle[8*k +: 8]);
                    sent += run;
                end
                6, 7:
                begin
                    k = $urandom_range(0, span - 1);
                    push_byte(shadow_needle[8*k +: 8]);
                    sent++;
                end
                default:
                begin
                    push_byte(8'($urandom));
                    sent++;
                end
            endcase
        end
    endtask

    // Result side: random stalls, fast stretches, one long hold-off on request
    initial
    begin : result_sink
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req && !hold_served)
            begin
                m_tready <= 1'b0;
                repeat (60) @(negedge clk);
                hold_served = 1'b1;
            end
            if ($urandom_range(0, 15) == 0)
                sink_fast = !sink_fast;
            gap = sink_fast ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int phase;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: one-byte needle of zero, store mode, full limit
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'h7F);
        drain();

        // length zero acts as one, count zero acts as a limit of one
        write_reg(REG_NEEDLE_BYTES, 64'hF0E1_D2C3_B4A5_9687);
        write_reg(REG_NEEDLE_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
        write_reg(REG_MAX_COUNT, 64'hFFFF_FFFF_FFFF_0000);
        push_byte(8'h87);   // found and limit on the same byte
        push_byte(8'h00);   // limit alone
        drain();

        // oversized length saturates; stop three bytes into the needle
        write_reg(REG_NEEDLE_LENGTH, 64'h0000_0000_0000_000F);
        write_reg(REG_MAX_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
        push_byte(8'h87);
        push_byte(8'h96);
        push_byte(8'hA5);
        drain();

        // discard mode mid-search; position now past the shortened needle
        write_reg(REG_STORE_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(REG_NEEDLE_LENGTH, 64'h0000_0000_0000_0002);
        push_byte(8'h87);
        drain();

        // back to store mode with the limit dropped under the running count
        write_reg(REG_STORE_MODE, 64'h0000_0000_0000_0001);
        write_reg(REG_MAX_COUNT, 64'h0000_0000_0000_0002);
        push_byte(8'h00);
        drain();

        // zero bytes inside the needle are ordinary needle bytes
        write_reg(REG_NEEDLE_BYTES, 64'h0);
        write_reg(REG_NEEDLE_LENGTH, 64'h0000_0000_0000_0008);
        write_reg(REG_MAX_COUNT, 64'h0000_0000_0000_FFFF);
        repeat (8) push_byte(8'h00);
        drain();
        write_reg(REG_STORE_MODE, 64'h0);
        write_reg(REG_NEEDLE_LENGTH, 64'h0000_0000_0000_0003);
        repeat (3) push_byte(8'h00);
        drain();

        // random phases; one of them runs against a long result-side stall
        for (phase = 0; phase < 19; phase++)
        begin
            random_setup(phase == 0);
            if (phase == 9)
            begin
                hold_req  = 1'b1;
                src_burst = 1'b1;
                random_traffic(24);
                src_burst = 1'b0;
            end
            else
            begin
                random_traffic(20);
            end
            drain();
        end

        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && results_outstanding == 0)
            $display("serial_needle_wait_matcher_top_tb: clean");
        else
            $display("serial_needle_wait_matcher_top_tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
src/snwm_pkg.sv
src/snwm_cfg.sv
src/snwm_core.sv
src/serial_needle_wait_matcher_top.sv
tb/serial_needle_wait_matcher_checker.sv
tb/serial_needle_wait_matcher_top_tb.sv
